// ----- hdl/ccsb_pkg.sv -----
// Package for the C comment and string blanker.
// Holds the character codes and the result slot type; no dependencies.
`timescale 1ns / 1ps

package ccsb_pkg;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_end;
    } res_t;

endpackage

// ----- hdl/c_comment_string_blanker.sv -----
// Top level of the C comment and string blanker.
// Depends on ccsb_pkg (character codes, result slot type).
`timescale 1ns / 1ps

// Usage:
//   Input channel: in_valid / in_stall carry one text byte (in_byte) and
//   text_last, which marks the final byte of a text.
//   Output channel: out_valid / out_stall carry out_byte, run_last (last
//   result of its input item) and text_end (final result of the text).
//   Each input item yields zero, one or two result items; a non-final '/'
//   in code is held until the next byte shows whether it opens a comment.
//   A result is presented in the cycle after its input item is taken.
//   Throughput: one input item per cycle while each gives at most one
//   result and out_stall is low; an item with two results stalls input
//   until its first result is taken, so one item per result cycle.
//   The lexer mode register and a two-slot result buffer are the only
//   state; the buffer must be empty, or emptying this cycle, to take input.
//   Reset (rst_n low, asynchronous) puts the lexer in code mode with no
//   held slash and empties the result buffer.
//   When the receiver stalls, the presented result holds and in_stall
//   rises as soon as the buffer cannot drain in the same cycle.
module c_comment_string_blanker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       text_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       text_end
);

    typedef enum logic [3:0] {
        M_NORMAL = 4'd0,
        M_HELD   = 4'd1,
        M_LINE   = 4'd2,
        M_BLOCK  = 4'd3,
        M_BSTAR  = 4'd4,
        M_STR    = 4'd5,
        M_STRESC = 4'd6,
        M_CHR    = 4'd7,
        M_CHRESC = 4'd8
    } mode_t;

    mode_t           mode_reg, mode_next;
    logic [1:0]      cnt_reg;
    ccsb_pkg::res_t  slot0_reg, slot1_reg;

    logic            in_acc, out_acc;
    logic [1:0]      n_res;
    logic [7:0]      b0, b1;
    logic            nb_has;
    logic [7:0]      nb_byte;
    mode_t           nb_mode;
    ccsb_pkg::res_t  r0, r1;

    assign out_valid = (cnt_reg != 2'd0);
    assign out_acc   = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && !out_stall));
    assign in_acc    = in_valid && !in_stall;

    assign out_byte  = slot0_reg.data;
    assign run_last  = slot0_reg.run_last;
    assign text_end  = slot0_reg.text_end;

    // code-mode handling of a byte
    always_comb
    begin
        nb_has  = 1'b1;
        nb_byte = in_byte;
        nb_mode = M_NORMAL;
        if (in_byte == ccsb_pkg::CH_SLASH)
        begin
            nb_has  = text_last;
            nb_byte = ccsb_pkg::CH_SLASH;
            nb_mode = text_last ? M_NORMAL : M_HELD;
        end
        else if (in_byte == ccsb_pkg::CH_DQUOTE)
        begin
            nb_byte = ccsb_pkg::CH_SPACE;
            nb_mode = M_STR;
        end
        else if (in_byte == ccsb_pkg::CH_SQUOTE)
        begin
            nb_byte = ccsb_pkg::CH_SPACE;
            nb_mode = M_CHR;
        end
    end

    always_comb
    begin
        n_res     = 2'd1;
        b0        = ccsb_pkg::CH_SPACE;
        b1        = ccsb_pkg::CH_SPACE;
        mode_next = mode_reg;
        unique case (mode_reg)
            M_HELD:
            begin
                if (in_byte == ccsb_pkg::CH_SLASH)
                begin
                    n_res     = 2'd2;
                    mode_next = M_LINE;
                end
                else if (in_byte == ccsb_pkg::CH_STAR)
                begin
                    n_res     = 2'd2;
                    mode_next = M_BLOCK;
                end
                else
                begin
                    b0        = ccsb_pkg::CH_SLASH;
                    b1        = nb_byte;
                    n_res     = nb_has ? 2'd2 : 2'd1;
                    mode_next = nb_mode;
                end
            end
            M_LINE:
            begin
                if (in_byte == ccsb_pkg::CH_NL)
                begin
                    b0        = ccsb_pkg::CH_NL;
                    mode_next = M_NORMAL;
                end
            end
            M_BLOCK, M_BSTAR:
            begin
                if (in_byte == ccsb_pkg::CH_NL)
                begin
                    b0        = ccsb_pkg::CH_NL;
                    mode_next = M_BLOCK;
                end
                else if (in_byte == ccsb_pkg::CH_SLASH && mode_reg == M_BSTAR)
                    mode_next = M_NORMAL;
                else if (in_byte == ccsb_pkg::CH_STAR)
                    mode_next = M_BSTAR;
                else
                    mode_next = M_BLOCK;
            end
            M_STR, M_CHR:
            begin
                if (in_byte == ccsb_pkg::CH_NL)
                begin
                    b0        = ccsb_pkg::CH_NL;
                    mode_next = M_NORMAL;
                end
                else if (in_byte == ccsb_pkg::CH_BSLASH)
                    mode_next = (mode_reg == M_STR) ? M_STRESC : M_CHRESC;
                else if ((mode_reg == M_STR && in_byte == ccsb_pkg::CH_DQUOTE) ||
                         (mode_reg == M_CHR && in_byte == ccsb_pkg::CH_SQUOTE))
                    mode_next = M_NORMAL;
            end
            M_STRESC, M_CHRESC:
            begin
                if (in_byte == ccsb_pkg::CH_NL)
                begin
                    b0        = ccsb_pkg::CH_NL;
                    mode_next = M_NORMAL;
                end
                else
                    mode_next = (mode_reg == M_STRESC) ? M_STR : M_CHR;
            end
            default:
            begin
                b0        = nb_byte;
                n_res     = nb_has ? 2'd1 : 2'd0;
                mode_next = nb_mode;
            end
        endcase
        if (text_last)
            mode_next = M_NORMAL;
    end

    assign r0 = '{data: b0, run_last: (n_res == 2'd1), text_end: (n_res == 2'd1) && text_last};
    assign r1 = '{data: b1, run_last: 1'b1, text_end: text_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_NORMAL;
            cnt_reg   <= 2'd0;
            slot0_reg <= '0;
            slot1_reg <= '0;
        end
        else if (in_acc)
        begin
            mode_reg  <= mode_next;
            cnt_reg   <= n_res;
            slot0_reg <= r0;
            slot1_reg <= r1;
        end
        else if (out_acc)
        begin
            cnt_reg   <= cnt_reg - 2'd1;
            slot0_reg <= slot1_reg;
        end
    end

endmodule

// ----- hdl/ccsb_checker.sv -----
// Port-level checker for the C comment and string blanker, with its bind.
// Depends on ccsb_pkg (character codes) and c_comment_string_blanker.
`timescale 1ns / 1ps

module ccsb_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       text_last,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       run_last,
    input logic       text_end
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) &&
        $stable(run_last) && $stable(text_end))
        else $error("output item changed under stall");

    a_end_is_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_end |-> run_last)
        else $error("text_end without run_last");

    a_nonslash_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (in_byte != ccsb_pkg::CH_SLASH) |=> out_valid)
        else $error("item with a result produced no output");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && text_last |=> out_valid)
        else $error("final item produced no output");

endmodule

bind c_comment_string_blanker ccsb_checker u_ccsb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .text_last (text_last),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .text_end  (text_end)
);

// ----- test/c_comment_string_blanker_tb.sv -----
// Testbench for c_comment_string_blanker: a directed table, then random C-like texts, each
// item checked against typed rows or a built-in lexer predictor under random or no idling.
// Depends on ccsb_pkg (character codes, result slot type) and the block's RTL.
`timescale 1ns / 1ps

module c_comment_string_blanker_tb;

    typedef enum logic [3:0]
    {
        LX_CODE,
        LX_SLASH,
        LX_LINE,
        LX_BLOCK,
        LX_BLOCK_STAR,
        LX_STR,
        LX_STR_ESC,
        LX_CHR,
        LX_CHR_ESC
    } lex_t;

    typedef struct
    {
        logic [7:0] b;
        logic       l;
        int         n;
        logic [7:0] r0;
        logic [7:0] r1;
    } dir_row_t;

    localparam int NO_TYPED = -1;
    localparam int DIR_ROWS = 28;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte = 8'h00;
    logic       text_last = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       text_end;

    int         cur_n = NO_TYPED;
    logic [7:0] cur_r0 = 8'h00;
    logic [7:0] cur_r1 = 8'h00;

    int         src_idle_pct = 27;
    int         snk_idle_pct = 56;
    int         err_cnt = 0;
    int         sent = 0;

    lex_t            lex_q = LX_CODE;
    logic [7:0]      emit_buf [0:1];
    int              emit_n;
    ccsb_pkg::res_t  blank_exp_q [$];
    ccsb_pkg::res_t  exp_r;
    ccsb_pkg::res_t  new_r;
    logic [7:0]      text_q [$];

    dir_row_t dir_tab [0:DIR_ROWS-1] = '{
        '{8'h61,               1'b0, 1,        8'h61,               8'h00},
        '{8'h00,               1'b0, 1,        8'h00,               8'h00},
        '{8'hFF,               1'b0, 1,        8'hFF,               8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, 0,        8'h00,               8'h00},
        '{8'h78,               1'b0, 2,        ccsb_pkg::CH_SLASH,  8'h78},
        '{ccsb_pkg::CH_SLASH,  1'b0, 0,        8'h00,               8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, 2,        ccsb_pkg::CH_SPACE,  ccsb_pkg::CH_SPACE},
        '{8'hFF,               1'b0, 1,        ccsb_pkg::CH_SPACE,  8'h00},
        '{ccsb_pkg::CH_NL,     1'b0, 1,        ccsb_pkg::CH_NL,     8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, 0,        8'h00,               8'h00},
        '{ccsb_pkg::CH_STAR,   1'b0, 2,        ccsb_pkg::CH_SPACE,  ccsb_pkg::CH_SPACE},
        '{ccsb_pkg::CH_SLASH,  1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_NL,     1'b0, 1,        ccsb_pkg::CH_NL,     8'h00},
        '{ccsb_pkg::CH_STAR,   1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_DQUOTE, 1'b0, 1,        ccsb_pkg::CH_SPACE,  8'h00},
        '{ccsb_pkg::CH_BSLASH, 1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_DQUOTE, 1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_BSLASH, 1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_NL,     1'b0, 1,        ccsb_pkg::CH_NL,     8'h00},
        '{ccsb_pkg::CH_SQUOTE, 1'b0, 1,        ccsb_pkg::CH_SPACE,  8'h00},
        '{ccsb_pkg::CH_SQUOTE, 1'b0, NO_TYPED, 8'h00,               8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, 0,        8'h00,               8'h00},
        '{ccsb_pkg::CH_DQUOTE, 1'b0, 2,        ccsb_pkg::CH_SLASH,  ccsb_pkg::CH_SPACE},
        '{8'h7A,               1'b1, 1,        ccsb_pkg::CH_SPACE,  8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b1, 1,        ccsb_pkg::CH_SLASH,  8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b0, 0,        8'h00,               8'h00},
        '{ccsb_pkg::CH_SLASH,  1'b1, 2,        ccsb_pkg::CH_SPACE,  ccsb_pkg::CH_SPACE}
    };

    c_comment_string_blanker dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .text_last (text_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .run_last  (run_last),
        .text_end  (text_end)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("FAIL");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic void put_byte(input logic [7:0] c);
        if (emit_n < 2)
        begin
            emit_buf[emit_n] = c;
            emit_n++;
        end
    endfunction

    function automatic void add_byte(input logic [7:0] c);
        text_q.insert(text_q.size(), c);
    endfunction

    function automatic void code_byte(input logic [7:0] c, input logic l);
        if (c == ccsb_pkg::CH_SLASH)
        begin
            if (l)
                put_byte(ccsb_pkg::CH_SLASH);
            else
                lex_q = LX_SLASH;
        end
        else if (c == ccsb_pkg::CH_DQUOTE)
        begin
            put_byte(ccsb_pkg::CH_SPACE);
            lex_q = LX_STR;
        end
        else if (c == ccsb_pkg::CH_SQUOTE)
        begin
            put_byte(ccsb_pkg::CH_SPACE);
            lex_q = LX_CHR;
        end
        else
        begin
            put_byte(c);
            lex_q = LX_CODE;
        end
    endfunction

    function automatic void predict_blank(input logic [7:0] c, input logic l);
        emit_n = 0;
        case (lex_q)
            LX_SLASH:
            begin
                if (c == ccsb_pkg::CH_SLASH || c == ccsb_pkg::CH_STAR)
                begin
                    put_byte(ccsb_pkg::CH_SPACE);
                    put_byte(ccsb_pkg::CH_SPACE);
                    lex_q = (c == ccsb_pkg::CH_SLASH) ? LX_LINE : LX_BLOCK;
                end
                else
                begin
                    put_byte(ccsb_pkg::CH_SLASH);
                    code_byte(c, l);
                end
            end
            LX_LINE:
            begin
                if (c == ccsb_pkg::CH_NL)
                begin
                    put_byte(ccsb_pkg::CH_NL);
                    lex_q = LX_CODE;
                end
                else
                    put_byte(ccsb_pkg::CH_SPACE);
            end
            LX_BLOCK, LX_BLOCK_STAR:
            begin
                if (c == ccsb_pkg::CH_NL)
                begin
                    put_byte(ccsb_pkg::CH_NL);
                    lex_q = LX_BLOCK;
                end
                else
                begin
                    put_byte(ccsb_pkg::CH_SPACE);
                    if (c == ccsb_pkg::CH_SLASH && lex_q == LX_BLOCK_STAR)
                        lex_q = LX_CODE;
                    else if (c == ccsb_pkg::CH_STAR)
                        lex_q = LX_BLOCK_STAR;
                    else
                        lex_q = LX_BLOCK;
                end
            end
            LX_STR, LX_CHR:
            begin
                if (c == ccsb_pkg::CH_NL)
                begin
                    put_byte(ccsb_pkg::CH_NL);
                    lex_q = LX_CODE;
                end
                else
                begin
                    put_byte(ccsb_pkg::CH_SPACE);
                    if (c == ccsb_pkg::CH_BSLASH)
                        lex_q = (lex_q == LX_STR) ? LX_STR_ESC : LX_CHR_ESC;
                    else if (c == ((lex_q == LX_STR) ? ccsb_pkg::CH_DQUOTE
                                                     : ccsb_pkg::CH_SQUOTE))
                        lex_q = LX_CODE;
                end
            end
            LX_STR_ESC, LX_CHR_ESC:
            begin
                if (c == ccsb_pkg::CH_NL)
                begin
                    put_byte(ccsb_pkg::CH_NL);
                    lex_q = LX_CODE;
                end
                else
                begin
                    put_byte(ccsb_pkg::CH_SPACE);
                    lex_q = (lex_q == LX_STR_ESC) ? LX_STR : LX_CHR;
                end
            end
            default:
                code_byte(c, l);
        endcase
        if (l)
            lex_q = LX_CODE;
    endfunction

    // check the presented result first, then queue what the accepted item causes
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (blank_exp_q.size() == 0)
                report_mismatch($sformatf("unexpected item byte=%h", out_byte));
            else
            begin
                exp_r = blank_exp_q.pop_front();
                if (out_byte !== exp_r.data)
                    report_mismatch($sformatf("out_byte %h, want %h", out_byte, exp_r.data));
                if (run_last !== exp_r.run_last)
                    report_mismatch($sformatf("run_last %b, want %b", run_last, exp_r.run_last));
                if (text_end !== exp_r.text_end)
                    report_mismatch($sformatf("text_end %b, want %b", text_end, exp_r.text_end));
            end
        end
        if (rst_n && in_valid && !in_stall)
        begin
            predict_blank(in_byte, text_last);
            if (cur_n != NO_TYPED)
            begin
                emit_n = cur_n;
                emit_buf[0] = cur_r0;
                emit_buf[1] = cur_r1;
            end
            for (int k = 0; k < emit_n; k++)
            begin
                new_r = '{emit_buf[k], k == emit_n - 1, (k == emit_n - 1) && text_last};
                blank_exp_q.insert(blank_exp_q.size(), new_r);
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < snk_idle_pct);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_byte(input logic [7:0] b, input logic l, input int n,
                             input logic [7:0] r0, input logic [7:0] r1);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_byte   <= b;
        text_last <= l;
        cur_n     <= n;
        cur_r0    <= r0;
        cur_r1    <= r1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    function automatic logic [7:0] any_byte();
        case ($urandom_range(11))
            0: return ccsb_pkg::CH_SLASH;
            1: return ccsb_pkg::CH_STAR;
            2: return ccsb_pkg::CH_DQUOTE;
            3: return ccsb_pkg::CH_SQUOTE;
            4: return ccsb_pkg::CH_BSLASH;
            5: return ccsb_pkg::CH_NL;
            6, 7: return 8'h61 + 8'($urandom_range(25));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // mostly lowercase letters, now and then any byte
    function automatic logic [7:0] body_byte();
        if ($urandom_range(3) == 0)
            return any_byte();
        return 8'h61 + 8'($urandom_range(25));
    endfunction

    function automatic void add_fragment();
        int len;
        len = $urandom_range(6);
        case ($urandom_range(7))
            0:
            begin
                add_byte(ccsb_pkg::CH_SLASH);
                add_byte(ccsb_pkg::CH_SLASH);
                repeat (len) add_byte(body_byte());
                add_byte(ccsb_pkg::CH_NL);
            end
            1:
            begin
                add_byte(ccsb_pkg::CH_SLASH);
                add_byte(ccsb_pkg::CH_STAR);
                repeat (len) add_byte(body_byte());
                if ($urandom_range(2) == 0)
                    add_byte(ccsb_pkg::CH_NL);
                add_byte(ccsb_pkg::CH_STAR);
                add_byte(ccsb_pkg::CH_SLASH);
            end
            2:
            begin
                add_byte(ccsb_pkg::CH_DQUOTE);
                repeat (len)
                begin
                    if ($urandom_range(3) == 0)
                        add_byte(ccsb_pkg::CH_BSLASH);
                    add_byte(body_byte());
                end
                add_byte(ccsb_pkg::CH_DQUOTE);
            end
            3:
            begin
                add_byte(ccsb_pkg::CH_SQUOTE);
                if ($urandom_range(1) == 0)
                    add_byte(ccsb_pkg::CH_BSLASH);
                add_byte(body_byte());
                add_byte(ccsb_pkg::CH_SQUOTE);
            end
            4:
            begin
                add_byte(8'h61 + 8'($urandom_range(25)));
                add_byte(ccsb_pkg::CH_SLASH);
                add_byte(8'h61 + 8'($urandom_range(25)));
            end
            5:
                add_byte(ccsb_pkg::CH_NL);
            default:
                repeat (len + 1) add_byte(any_byte());
        endcase
    endfunction

    task automatic send_random_text();
        int frags;
        int last_i;
        frags = $urandom_range(10, 1);
        text_q.delete();
        repeat (frags) add_fragment();
        last_i = text_q.size() - 1;
        for (int i = 0; i <= last_i; i++)
            push_byte(text_q[i], i == last_i, NO_TYPED, 8'h00, 8'h00);
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            push_byte(dir_tab[i].b, dir_tab[i].l, dir_tab[i].n, dir_tab[i].r0, dir_tab[i].r1);

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct = (ph == 0) ? 27 : (ph == 1) ? 56 : 0;
            snk_idle_pct = (ph == 0) ? 56 : (ph == 1) ? 27 : 0;
            while (sent < DIR_ROWS + (ph + 1) * 624)
                send_random_text();
        end
        in_valid <= 1'b0;

        while (blank_exp_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
